// ----- src/ges_pkg.sv -----
// Shared constants and types for the gravity Euler body step block.
`timescale 1ns / 1ps
`default_nettype none
package ges_pkg;

  localparam int WORD_W        = 32;
  localparam int DT_W          = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [WORD_W-1:0] RST_BODY_MASS  = 32'd65536;
  localparam logic [WORD_W-1:0] RST_GRAV_CONST = 32'd65536;
  localparam logic [DT_W-1:0]   RST_TIME_STEP  = 24'd1092;

  localparam logic [1:0] CFG_BODY_MASS  = 2'd0;
  localparam logic [1:0] CFG_GRAV_CONST = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef logic signed [WORD_W-1:0] sword_t;
  typedef logic        [WORD_W-1:0] uword_t;

endpackage
`default_nettype wire

// ----- src/ges_in_if.sv -----
// Input channel: load or step word with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface ges_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  ges_pkg::sword_t load_pos_x;
  ges_pkg::sword_t load_pos_y;
  ges_pkg::sword_t load_vel_x;
  ges_pkg::sword_t load_vel_y;
  ges_pkg::sword_t partner_x;
  ges_pkg::sword_t partner_y;
  ges_pkg::uword_t partner_mass;

  modport source (
    output valid, command, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
           partner_x, partner_y, partner_mass,
    input  ready
  );
  modport sink (
    input  valid, command, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
           partner_x, partner_y, partner_mass,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/ges_out_if.sv -----
// Result channel: new body state, applied force and flags.
`timescale 1ns / 1ps
`default_nettype none
interface ges_out_if;
  logic            valid;
  logic            ready;
  ges_pkg::sword_t new_pos_x;
  ges_pkg::sword_t new_pos_y;
  ges_pkg::sword_t new_vel_x;
  ges_pkg::sword_t new_vel_y;
  ges_pkg::sword_t force_out_x;
  ges_pkg::sword_t force_out_y;
  logic            coincident;
  logic            saturated;

  modport source (
    output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
           force_out_x, force_out_y, coincident, saturated,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
           force_out_x, force_out_y, coincident, saturated,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/gravity_euler_body_step.sv -----
// Top level: one body's gravity force and explicit Euler step, sequenced.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+----------------------------------------
//  in_ch   | in  | valid/ready      | command, load pos/vel, partner pos/mass
//  out_ch  | out | valid/ready      | new pos/vel, force, coincident, saturated
//  cfg_*   | in  | cfg_we, no wait  | body_mass, grav_const, time_step
//
//  A load word goes straight to hand-over; its result waits for a free output register.
//  A step word runs through one shared restoring divider / square-root unit
//  retiring one bit a cycle, which does a 32-step root and up to five 64-step
//  divisions (only the two acceleration divisions when the bodies coincide).
//  rst_n is synchronous: it clears the sequencer, the body state and the
//  registers to their reset values. in_ch.ready is high only while idle;
//  a finished result waits in the output register while the next word enters.
`timescale 1ns / 1ps
`default_nettype none
module gravity_euler_body_step #(
  parameter int FRAC_BITS = ges_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  ges_in_if.sink           in_ch,
  ges_out_if.source        out_ch
);

  typedef enum logic [26:0] {
    ST_IDLE   = 27'h0000001,
    ST_DIFF   = 27'h0000002,
    ST_SCALE  = 27'h0000004,
    ST_SQA    = 27'h0000008,
    ST_SQB    = 27'h0000010,
    ST_MG     = 27'h0000020,
    ST_PL     = 27'h0000040,
    ST_PH     = 27'h0000080,
    ST_PSUM   = 27'h0000100,
    ST_NSHIFT = 27'h0000200,
    ST_UNIT   = 27'h0000400,
    ST_FDIV   = 27'h0000800,
    ST_FQ     = 27'h0001000,
    ST_FML    = 27'h0002000,
    ST_FMH    = 27'h0004000,
    ST_FSUM   = 27'h0008000,
    ST_FCHK   = 27'h0010000,
    ST_FCAP   = 27'h0020000,
    ST_EDIV   = 27'h0040000,
    ST_EAL    = 27'h0080000,
    ST_EAH    = 27'h0100000,
    ST_ESUM   = 27'h0200000,
    ST_EDV    = 27'h0400000,
    ST_EVEL   = 27'h0800000,
    ST_EPM    = 27'h1000000,
    ST_EPOS   = 27'h2000000,
    ST_DONE   = 27'h4000000
  } state_t;

  localparam logic [95:0] DV_CAP = 96'h2_0000_0000;

  state_t state_r, ret_r;

  // configuration and body state
  logic [31:0]        mass_r, grav_r;
  logic [23:0]        dt_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;

  // working registers of one step
  logic signed [31:0] px_r, py_r;
  logic [31:0]        m2_r;
  logic [31:0]        ux_r, uy_r;
  logic               nx_r, ny_r, k_r;
  logic [30:0]        a_r, b_r;
  logic [62:0]        s_r;
  logic [31:0]        r_r, phi_r, acc_hi_r;
  logic [95:0]        num_r;
  logic [63:0]        f_r, prod_r;
  logic [31:0]        fmx_r, fmy_r;
  logic               coin_r, clip_r, axis_r;
  logic [33:0]        dv_r;

  // shared divide / square-root unit
  logic        u_sqrt_r;
  logic [63:0] u_rem_r, u_lo_r, u_q_r, u_d_r;
  logic [6:0]  u_cnt_r;

  // result register
  logic               out_valid_r;
  logic signed [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r, o_fx_r, o_fy_r;
  logic               o_coin_r, o_sat_r;

  // combinational helpers
  logic [32:0]        ex_x, ex_y;
  logic [31:0]        mag_x, mag_y;
  logic [30:0]        sel_mag;
  logic               sel_neg;
  logic [31:0]        sel_fm;
  logic signed [31:0] sel_vel, sel_pos;
  logic [31:0]        vabs, mass_eff;
  logic [63:0]        cap;
  logic [31:0]        mul_a, mul_b;
  logic [64:0]        u_t, u_tsub;
  logic               u_ge, u_sge;
  logic [63:0]        u_sum;
  logic [95:0]        dvq;
  logic [35:0]        vsum, dv_s;
  logic signed [31:0] vel_nxt, pos_nxt;
  logic               vel_clip, pos_clip;
  logic [63:0]        dpq;
  logic [57:0]        psum, dp_s;
  logic               out_load;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.new_pos_x   = o_px_r;
  assign out_ch.new_pos_y   = o_py_r;
  assign out_ch.new_vel_x   = o_vx_r;
  assign out_ch.new_vel_y   = o_vy_r;
  assign out_ch.force_out_x = o_fx_r;
  assign out_ch.force_out_y = o_fy_r;
  assign out_ch.coincident  = o_coin_r;
  assign out_ch.saturated   = o_sat_r;

  // hand over once the output register is free or being emptied
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    // separation from this body to the partner, as magnitude and sign
    ex_x  = {px_r[31], px_r} - {pos_x_r[31], pos_x_r};
    ex_y  = {py_r[31], py_r} - {pos_y_r[31], pos_y_r};
    mag_x = ex_x[32] ? 32'(~ex_x + 33'd1) : ex_x[31:0];
    mag_y = ex_y[32] ? 32'(~ex_y + 33'd1) : ex_y[31:0];

    sel_mag  = axis_r ? b_r : a_r;
    sel_neg  = axis_r ? ny_r : nx_r;
    sel_fm   = axis_r ? fmy_r : fmx_r;
    sel_vel  = axis_r ? vel_y_r : vel_x_r;
    sel_pos  = axis_r ? pos_y_r : pos_x_r;
    vabs     = sel_vel[31] ? (~sel_vel + 32'd1) : sel_vel;
    mass_eff = (mass_r == 32'd0) ? 32'd1 : mass_r;
    cap      = sel_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;

    // unit: one quotient bit or one root bit per cycle
    u_t    = {u_rem_r, u_lo_r[63]};
    u_ge   = (u_t >= {1'b0, u_d_r});
    u_tsub = u_t - {1'b0, u_d_r};
    u_sum  = u_q_r + u_d_r;
    u_sge  = (u_rem_r >= u_sum);

    // velocity update with saturation
    dvq      = num_r >> FRAC_BITS;
    dv_s     = sel_neg ? (36'd0 - {2'b0, dv_r}) : {2'b0, dv_r};
    vsum     = {{4{sel_vel[31]}}, sel_vel} + dv_s;
    vel_clip = (!vsum[35] && (vsum[34:31] != 4'h0)) || (vsum[35] && (vsum[34:31] != 4'hF));
    if (!vsum[35] && (vsum[34:31] != 4'h0)) begin
      vel_nxt = 32'sh7FFF_FFFF;
    end else if (vsum[35] && (vsum[34:31] != 4'hF)) begin
      vel_nxt = 32'sh8000_0000;
    end else begin
      vel_nxt = vsum[31:0];
    end

    // position update with the new velocity
    dpq      = prod_r >> FRAC_BITS;
    dp_s     = sel_vel[31] ? (58'd0 - {2'b0, dpq[55:0]}) : {2'b0, dpq[55:0]};
    psum     = {{26{sel_pos[31]}}, sel_pos} + dp_s;
    pos_clip = (!psum[57] && (psum[56:31] != 26'h0)) ||
               (psum[57] && (psum[56:31] != 26'h3FF_FFFF));
    if (!psum[57] && (psum[56:31] != 26'h0)) begin
      pos_nxt = 32'sh7FFF_FFFF;
    end else if (psum[57] && (psum[56:31] != 26'h3FF_FFFF)) begin
      pos_nxt = 32'sh8000_0000;
    end else begin
      pos_nxt = psum[31:0];
    end

    // operands of the shared multiplier
    unique case (state_r)
      ST_SQA: begin
        mul_a = {1'b0, a_r};
        mul_b = {1'b0, a_r};
      end
      ST_SQB: begin
        mul_a = {1'b0, b_r};
        mul_b = {1'b0, b_r};
      end
      ST_MG: begin
        mul_a = mass_r;
        mul_b = grav_r;
      end
      ST_PL: begin
        mul_a = prod_r[31:0];
        mul_b = m2_r;
      end
      ST_PH: begin
        mul_a = phi_r;
        mul_b = m2_r;
      end
      ST_FML: begin
        mul_a = f_r[31:0];
        mul_b = {1'b0, sel_mag};
      end
      ST_FMH: begin
        mul_a = f_r[63:32];
        mul_b = {1'b0, sel_mag};
      end
      ST_EAL: begin
        mul_a = u_q_r[31:0];
        mul_b = {8'b0, dt_r};
      end
      ST_EAH: begin
        mul_a = acc_hi_r;
        mul_b = {8'b0, dt_r};
      end
      ST_EPM: begin
        mul_a = vabs;
        mul_b = {8'b0, dt_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Sequencer, configuration, body state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      mass_r      <= ges_pkg::RST_BODY_MASS;
      grav_r      <= ges_pkg::RST_GRAV_CONST;
      dt_r        <= ges_pkg::RST_TIME_STEP;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ges_pkg::CFG_BODY_MASS:  mass_r <= cfg_data;
          ges_pkg::CFG_GRAV_CONST: grav_r <= cfg_data;
          ges_pkg::CFG_TIME_STEP:  dt_r   <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.command == ges_pkg::CMD_LOAD) begin
              pos_x_r <= in_ch.load_pos_x;
              pos_y_r <= in_ch.load_pos_y;
              vel_x_r <= in_ch.load_vel_x;
              vel_y_r <= in_ch.load_vel_y;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DIFF;
            end
          end
        end
        ST_DIFF:  state_r <= ST_SCALE;
        // bodies on top of each other: skip the force, drift only
        ST_SCALE: state_r <= (ux_r == 32'd0 && uy_r == 32'd0) ? ST_EDIV : ST_SQA;
        ST_SQA:   state_r <= ST_SQB;
        ST_SQB:   state_r <= ST_MG;
        ST_MG:    state_r <= ST_PL;
        ST_PL:    state_r <= ST_PH;
        ST_PH:    state_r <= ST_PSUM;
        ST_PSUM:  state_r <= ST_NSHIFT;
        ST_NSHIFT: begin
          state_r <= ST_UNIT;
          ret_r   <= ST_FDIV;
        end
        ST_UNIT: begin
          if (u_cnt_r == 7'd1) begin
            state_r <= ret_r;
          end
        end
        ST_FDIV: begin
          // quotient beyond 64 bits: clip the force magnitude, no division
          if ({32'b0, num_r[95:64]} >= {1'b0, s_r}) begin
            state_r <= ST_FML;
          end else begin
            state_r <= ST_UNIT;
            ret_r   <= ST_FQ;
          end
        end
        ST_FQ:   state_r <= ST_FML;
        ST_FML:  state_r <= ST_FMH;
        ST_FMH:  state_r <= ST_FSUM;
        ST_FSUM: state_r <= ST_FCHK;
        ST_FCHK: begin
          if (num_r[95:64] >= r_r) begin
            state_r <= axis_r ? ST_EDIV : ST_FML;
          end else begin
            state_r <= ST_UNIT;
            ret_r   <= ST_FCAP;
          end
        end
        ST_FCAP: state_r <= axis_r ? ST_EDIV : ST_FML;
        ST_EDIV: begin
          state_r <= ST_UNIT;
          ret_r   <= ST_EAL;
        end
        ST_EAL:  state_r <= ST_EAH;
        ST_EAH:  state_r <= ST_ESUM;
        ST_ESUM: state_r <= ST_EDV;
        ST_EDV:  state_r <= ST_EVEL;
        ST_EVEL: begin
          if (axis_r) begin
            vel_y_r <= vel_nxt;
          end else begin
            vel_x_r <= vel_nxt;
          end
          state_r <= ST_EPM;
        end
        ST_EPM: state_r <= ST_EPOS;
        ST_EPOS: begin
          if (axis_r) begin
            pos_y_r <= pos_nxt;
          end else begin
            pos_x_r <= pos_nxt;
          end
          state_r <= axis_r ? ST_DONE : ST_EDIV;
        end
        ST_DONE: begin
          // hold here while the previous result still waits
          if (out_load) begin
            o_px_r   <= pos_x_r;
            o_py_r   <= pos_y_r;
            o_vx_r   <= vel_x_r;
            o_vy_r   <= vel_y_r;
            o_fx_r   <= nx_r ? (32'sd0 - fmx_r) : fmx_r;
            o_fy_r   <= ny_r ? (32'sd0 - fmy_r) : fmy_r;
            o_coin_r <= coin_r;
            o_sat_r  <= clip_r;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath of one step.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    unique case (state_r)
      ST_IDLE: begin
        px_r   <= in_ch.partner_x;
        py_r   <= in_ch.partner_y;
        m2_r   <= in_ch.partner_mass;
        fmx_r  <= '0;
        fmy_r  <= '0;
        nx_r   <= 1'b0;
        ny_r   <= 1'b0;
        coin_r <= 1'b0;
        clip_r <= 1'b0;
        axis_r <= 1'b0;
      end
      ST_DIFF: begin
        ux_r <= mag_x;
        uy_r <= mag_y;
        nx_r <= ex_x[32];
        ny_r <= ex_y[32];
      end
      ST_SCALE: begin
        // halve both components when one no longer fits 31 bits
        k_r <= ux_r[31] | uy_r[31];
        a_r <= (ux_r[31] | uy_r[31]) ? ux_r[31:1] : ux_r[30:0];
        b_r <= (ux_r[31] | uy_r[31]) ? uy_r[31:1] : uy_r[30:0];
        if (ux_r == 32'd0 && uy_r == 32'd0) begin
          coin_r <= 1'b1;
        end
      end
      ST_SQB:  s_r <= prod_r[62:0];
      ST_MG:   s_r <= s_r + prod_r[62:0];
      ST_PL:   phi_r <= prod_r[63:32];
      ST_PH:   num_r <= {32'b0, prod_r};
      ST_PSUM: num_r <= num_r + {prod_r, 32'b0};
      ST_NSHIFT: begin
        num_r    <= num_r >> {k_r, 1'b0};
        u_sqrt_r <= 1'b1;
        u_rem_r  <= {1'b0, s_r};
        u_q_r    <= '0;
        u_d_r    <= 64'h4000_0000_0000_0000;
        u_cnt_r  <= 7'd32;
      end
      ST_UNIT: begin
        if (u_sqrt_r) begin
          if (u_sge) begin
            u_rem_r <= u_rem_r - u_sum;
            u_q_r   <= (u_q_r >> 1) + u_d_r;
          end else begin
            u_q_r <= u_q_r >> 1;
          end
          u_d_r <= u_d_r >> 2;
        end else begin
          u_rem_r <= u_ge ? u_tsub[63:0] : u_t[63:0];
          u_q_r   <= {u_q_r[62:0], u_ge};
          u_lo_r  <= u_lo_r << 1;
        end
        u_cnt_r <= u_cnt_r - 7'd1;
      end
      ST_FDIV: begin
        r_r <= u_q_r[31:0];
        if ({32'b0, num_r[95:64]} >= {1'b0, s_r}) begin
          f_r    <= '1;
          clip_r <= 1'b1;
        end else begin
          u_sqrt_r <= 1'b0;
          u_rem_r  <= {32'b0, num_r[95:64]};
          u_lo_r   <= num_r[63:0];
          u_q_r    <= '0;
          u_d_r    <= {1'b0, s_r};
          u_cnt_r  <= 7'd64;
        end
      end
      ST_FQ:   f_r <= u_q_r;
      ST_FMH:  num_r <= {32'b0, prod_r};
      ST_FSUM: num_r <= num_r + {prod_r, 32'b0};
      ST_FCHK: begin
        if (num_r[95:64] >= r_r) begin
          if (axis_r) begin
            fmy_r <= cap[31:0];
          end else begin
            fmx_r <= cap[31:0];
          end
          clip_r <= 1'b1;
          axis_r <= ~axis_r;
        end else begin
          u_sqrt_r <= 1'b0;
          u_rem_r  <= {32'b0, num_r[95:64]};
          u_lo_r   <= num_r[63:0];
          u_q_r    <= '0;
          u_d_r    <= {32'b0, r_r};
          u_cnt_r  <= 7'd64;
        end
      end
      ST_FCAP: begin
        if (u_q_r > cap) begin
          if (axis_r) begin
            fmy_r <= cap[31:0];
          end else begin
            fmx_r <= cap[31:0];
          end
          clip_r <= 1'b1;
        end else if (axis_r) begin
          fmy_r <= u_q_r[31:0];
        end else begin
          fmx_r <= u_q_r[31:0];
        end
        axis_r <= ~axis_r;
      end
      ST_EDIV: begin
        // acceleration = force / mass
        u_sqrt_r <= 1'b0;
        u_rem_r  <= '0;
        u_lo_r   <= {32'b0, sel_fm} << FRAC_BITS;
        u_q_r    <= '0;
        u_d_r    <= {32'b0, mass_eff};
        u_cnt_r  <= 7'd64;
      end
      ST_EAL:  acc_hi_r <= u_q_r[63:32];
      ST_EAH:  num_r <= {32'b0, prod_r};
      ST_ESUM: num_r <= num_r + {prod_r, 32'b0};
      ST_EDV:  dv_r <= (dvq > DV_CAP) ? DV_CAP[33:0] : dvq[33:0];
      ST_EVEL: begin
        if (vel_clip) begin
          clip_r <= 1'b1;
        end
      end
      ST_EPOS: begin
        if (pos_clip) begin
          clip_r <= 1'b1;
        end
        axis_r <= ~axis_r;
      end
      default: ;
    endcase
  end

  // a load word goes straight to hand-over
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.command == ges_pkg::CMD_LOAD))
      |=> (state_r == ST_DONE))
    else $error("load word did not go to hand-over");

  // coinciding bodies never report a force
  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_coin_r) |-> (o_fx_r == 32'sd0 && o_fy_r == 32'sd0))
    else $error("force reported with zero separation");

  // the shared unit never runs with an exhausted count
  a_unit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNIT) |-> (u_cnt_r != 7'd0))
    else $error("unit running with zero count");

  // a result appears only from hand-over
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside hand-over");

endmodule
`default_nettype wire
